[src/ubd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 byte decoder.
// Depends on nothing; used by every module of the block.
package ubd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodepointW = 21;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned RemainW    = 2;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [StatusW-1:0] StatusChar    = 2'd0;
  localparam logic [StatusW-1:0] StatusBadLead = 2'd1;
  localparam logic [StatusW-1:0] StatusBadCont = 2'd2;
  localparam logic [StatusW-1:0] StatusZero    = 2'd3;

  typedef enum logic [2:0] {
    ClsZero,
    ClsAscii,
    ClsLead2,
    ClsLead3,
    ClsLead4,
    ClsCont,
    ClsInvalid
  } byte_class_e;

  typedef struct packed {
    byte_class_e      cls;
    logic [ByteW-1:0] data;
  } ubd_item_t;

  function automatic byte_class_e classify(input logic [ByteW-1:0] b);
    byte_class_e c;
    if (b == '0) begin
      c = ClsZero;
    end else if (b[7] == 1'b0) begin
      c = ClsAscii;
    end else if (b[7:6] == 2'b10) begin
      c = ClsCont;
    end else if (b[7:5] == 3'b110) begin
      c = ClsLead2;
    end else if (b[7:4] == 4'b1110) begin
      c = ClsLead3;
    end else if (b[7:3] == 5'b11110) begin
      c = ClsLead4;
    end else begin
      c = ClsInvalid;
    end
    return c;
  endfunction

endpackage

[src/ubd_front.sv]
`timescale 1ns / 1ps
// Front end: accepts raw bytes and tags each with its byte class.
// Depends on ubd_pkg; feeds ubd_queue.
module ubd_front (
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              data_byte_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output ubd_pkg::ubd_item_t      push_item_o
);
  import ubd_pkg::*;

  assign in_ready_o       = !q_full_i;
  assign push_o           = in_valid_i && !q_full_i;
  assign push_item_o.cls  = classify(data_byte_i);
  assign push_item_o.data = data_byte_i;

endmodule

[src/ubd_queue.sv]
`timescale 1ns / 1ps
// Small FIFO of classified bytes between the front and back ends.
// Depends on ubd_pkg.
module ubd_queue #(
  parameter int unsigned Depth = ubd_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ubd_pkg::ubd_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output ubd_pkg::ubd_item_t pop_item_o
);
  import ubd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ubd_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[src/ubd_back.sv]
`timescale 1ns / 1ps
// Back end: sequence state, code point assembly and the output register.
// Depends on ubd_pkg; pops from ubd_queue.
module ubd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  ubd_pkg::ubd_item_t q_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [20:0]        codepoint_o,
  output logic [1:0]         status_o
);
  import ubd_pkg::*;

  localparam logic [RemainW-1:0] RemIdle = 2'd0;
  localparam logic [RemainW-1:0] RemOne  = 2'd1;
  localparam logic [RemainW-1:0] RemTwo  = 2'd2;
  localparam logic [RemainW-1:0] RemThree = 2'd3;

  logic [RemainW-1:0]    rem_q, rem_d;
  logic [CodepointW-1:0] part_q, part_d;
  logic                  out_valid_q, out_valid_d;
  logic [CodepointW-1:0] cp_q, cp_d;
  logic [StatusW-1:0]    st_q, st_d;
  logic                  emit;
  logic [CodepointW-1:0] emit_cp;
  logic [StatusW-1:0]    emit_st;
  logic [CodepointW-1:0] shifted;

  assign pop_o   = q_valid_i && (!out_valid_q || out_ready_i);
  assign shifted = {part_q[CodepointW-7:0], q_item_i.data[5:0]};

  always_comb begin
    rem_d   = rem_q;
    part_d  = part_q;
    emit    = 1'b0;
    emit_cp = '0;
    emit_st = StatusChar;
    if (pop_o) begin
      if (rem_q == RemIdle) begin
        unique case (q_item_i.cls)
          ClsZero: begin
            emit    = 1'b1;
            emit_st = StatusZero;
          end
          ClsAscii: begin
            emit    = 1'b1;
            emit_cp = CodepointW'(q_item_i.data);
          end
          ClsLead2: begin
            rem_d  = RemOne;
            part_d = CodepointW'(q_item_i.data[4:0]);
          end
          ClsLead3: begin
            rem_d  = RemTwo;
            part_d = CodepointW'(q_item_i.data[3:0]);
          end
          ClsLead4: begin
            rem_d  = RemThree;
            part_d = CodepointW'(q_item_i.data[2:0]);
          end
          default: begin
            emit    = 1'b1;
            emit_st = StatusBadLead;
          end
        endcase
      end else if (q_item_i.cls != ClsCont) begin
        rem_d   = RemIdle;
        part_d  = '0;
        emit    = 1'b1;
        emit_st = StatusBadCont;
      end else if (rem_q == RemOne) begin
        rem_d   = RemIdle;
        part_d  = '0;
        emit    = 1'b1;
        emit_cp = shifted;
      end else begin
        rem_d  = rem_q - 1'b1;
        part_d = shifted;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    cp_d        = cp_q;
    st_d        = st_q;
    if (emit) begin
      out_valid_d = 1'b1;
      cp_d        = emit_cp;
      st_d        = emit_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= RemIdle;
      part_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      part_q      <= part_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q <= cp_d;
    st_q <= st_d;
  end

  assign out_valid_o = out_valid_q;
  assign codepoint_o = cp_q;
  assign status_o    = st_q;

endmodule

[src/utf8_byte_decoder.sv]
`timescale 1ns / 1ps
// UTF-8 byte decoder, one byte per request, one result per finished sequence.
// An accepted byte is written into the queue, then popped by the back end, which
// registers any result that the byte completes in the output register.
// Throughput: one byte per cycle, held back only while a result waits untaken in the output register.
// Reset: asynchronous active low; clears the queue, sequence state and output valid.
module utf8_byte_decoder #(
  parameter int unsigned QueueDepth = ubd_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] codepoint_o,
  output logic [1:0]  status_o
);
  import ubd_pkg::*;

  logic      q_full, push, pop, q_valid;
  ubd_item_t push_item, pop_item;

  ubd_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  ubd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  ubd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .codepoint_o (codepoint_o),
    .status_o    (status_o)
  );

endmodule

[src/ubd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the UTF-8 byte decoder, bound to the top level.
// Depends on ubd_pkg and utf8_byte_decoder.
module ubd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  data_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [20:0] codepoint_o,
  input logic [1:0]  status_o
);
  import ubd_pkg::*;

  a_err_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StatusChar) |-> (codepoint_o == '0))
    else $error("non-character result carries a nonzero code point");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(codepoint_o) && $stable(status_o))
    else $error("stalled result changed or vanished");

  a_no_result_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(rst_ni))
    else $error("result appeared directly out of reset");

  a_known_handshake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_valid_i, in_ready_o, out_valid_o, out_ready_i}) &&
    (!in_valid_i || !$isunknown(data_byte_i)))
    else $error("handshake or offered byte is unknown");

endmodule

bind utf8_byte_decoder ubd_checker u_ubd_checker (.*);

[sim/tb_utf8_byte_decoder.sv]
`timescale 1ns / 1ps
// Self-checking testbench for utf8_byte_decoder: directed and random byte streams,
// checked against a behavioral decoder kept alongside. Depends on ubd_pkg and the RTL.
module tb_utf8_byte_decoder;
  import ubd_pkg::*;

  localparam int DrainMark     = -1;
  localparam int StallLimit    = 3000;
  localparam int HoldCycles    = 300;
  localparam int HoldAtResult  = 400;
  localparam int TotalBytes    = 1050;
  localparam int PhaseLen      = 350;

  typedef struct packed {
    logic [CodepointW-1:0] codepoint;
    logic [StatusW-1:0]    status;
  } decoded_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [ByteW-1:0]      data_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CodepointW-1:0] codepoint_o;
  logic [StatusW-1:0]    status_o;

  int       byte_q[$];
  decoded_t decoded_q[$];

  logic [RemainW-1:0]    seq_left  = '0;
  logic [CodepointW-1:0] seq_value = '0;

  int bytes_sent   = 0;
  int results_seen = 0;
  int err_count    = 0;
  int stall_count  = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  bit drain_wait   = 1'b0;
  int status_count[4] = '{0, 0, 0, 0};

  utf8_byte_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .codepoint_o (codepoint_o),
    .status_o    (status_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int send_idle_pct(input int n);
    if (n < PhaseLen) return 13;
    if (n < 2 * PhaseLen) return 60;
    return 0;
  endfunction

  function automatic int recv_idle_pct(input int n);
    if (n < PhaseLen) return 60;
    if (n < 2 * PhaseLen) return 13;
    return 0;
  endfunction

  task automatic decode_byte(input logic [ByteW-1:0] b);
    if (seq_left == '0) begin
      if (b == 8'h00) begin
        decoded_q.push_back('{codepoint: '0, status: StatusZero});
      end else if (!b[7]) begin
        decoded_q.push_back('{codepoint: {13'd0, b}, status: StatusChar});
      end else if (b[7:5] == 3'b110) begin
        seq_value = {16'd0, b[4:0]};
        seq_left  = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        seq_value = {17'd0, b[3:0]};
        seq_left  = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        seq_value = {18'd0, b[2:0]};
        seq_left  = 2'd3;
      end else begin
        decoded_q.push_back('{codepoint: '0, status: StatusBadLead});
      end
    end else if (b[7:6] != 2'b10) begin
      seq_left  = '0;
      seq_value = '0;
      decoded_q.push_back('{codepoint: '0, status: StatusBadCont});
    end else begin
      seq_value = {seq_value[CodepointW-7:0], b[5:0]};
      seq_left  = seq_left - 2'd1;
      if (seq_left == '0) begin
        decoded_q.push_back('{codepoint: seq_value, status: StatusChar});
        seq_value = '0;
      end
    end
  endtask

  // Driver: predicts each accepted request and offers the next pending byte, idling at random and at each drain mark.
  always @(posedge clk_i) begin
    int next_item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(data_byte_i);
        bytes_sent <= bytes_sent + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (drain_wait && decoded_q.size() == 0) drain_wait = 1'b0;
        if (!drain_wait && byte_q.size() > 0 && byte_q[0] == DrainMark) begin
          void'(byte_q.pop_front());
          drain_wait = 1'b1;
        end
        if (!drain_wait && byte_q.size() > 0 &&
            $urandom_range(99) >= send_idle_pct(bytes_sent)) begin
          next_item = byte_q.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= next_item[7:0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction; drives out_ready_i at random, with one hold.
  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        status_count[status_o] <= status_count[status_o] + 1;
        if (decoded_q.size() == 0) begin
          $error("unexpected result: codepoint %h status %0d", codepoint_o, status_o);
          err_count++;
        end else begin
          want = decoded_q.pop_front();
          if (codepoint_o !== want.codepoint) begin
            $error("codepoint mismatch: expected %h, actual %h", want.codepoint, codepoint_o);
            err_count++;
          end
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && results_seen >= HoldAtResult) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct(bytes_sent));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_count <= 0;
      end else if (stall_count >= StallLimit) begin
        $display("Timeout: no request accepted for %0d cycles.", StallLimit);
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  initial begin
    int kind;
    int len;
    int seq[4];
    bit mid_drain;
    mid_drain = 1'b0;

    byte_q = '{8'h00, 8'h41, 8'h7F,
               8'hC2, 8'hA9,
               8'hE2, 8'h82, 8'hAC,
               8'hF0, 8'h9F, 8'h98, 8'h80,
               8'hF7, 8'hBF, 8'hBF, 8'hBF,
               8'h80, 8'hF8, 8'hFF,
               8'hC0, 8'h80,
               8'hC3, 8'h00,
               8'hF0, 8'h9F, 8'hC3, 8'hA9,
               DrainMark};

    while (byte_q.size() < TotalBytes) begin
      if (!mid_drain && byte_q.size() > TotalBytes / 2) begin
        byte_q.push_back(DrainMark);
        mid_drain = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 75) begin
        len = $urandom_range(4, 1);
        case (len)
          1: seq[0] = $urandom_range(127);
          2: seq[0] = 8'hC0 | ($urandom & 8'h1F);
          3: seq[0] = 8'hE0 | ($urandom & 8'h0F);
          default: seq[0] = 8'hF0 | ($urandom & 8'h07);
        endcase
        for (int i = 1; i < len; i++) seq[i] = 8'h80 | ($urandom & 8'h3F);
        if (kind >= 65 && len > 1) seq[$urandom_range(len - 1, 1)] = $urandom_range(255);
        for (int i = 0; i < len; i++) byte_q.push_back(seq[i]);
      end else begin
        byte_q.push_back($urandom_range(255));
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (byte_q.size() > 0 || in_valid_i || decoded_q.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Summary: %0d bytes decoded into %0d results: %0d characters, %0d bad leads,",
             bytes_sent, results_seen, status_count[StatusChar], status_count[StatusBadLead]);
    $display("  %0d bad continuations, %0d terminators, with input and output stalls.",
             status_count[StatusBadCont], status_count[StatusZero]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
src/ubd_pkg.sv
src/ubd_front.sv
src/ubd_queue.sv
src/ubd_back.sv
src/utf8_byte_decoder.sv
src/ubd_checker.sv
sim/tb_utf8_byte_decoder.sv
